// ===== rtl/core/eop_pkg.sv =====
// Shared constants and helpers for the Euler offset placement block.
package eop_pkg;

  // Sine polynomial coefficients, Q15 over a quarter turn
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [14:0] SIN_B = 15'd21024;
  localparam logic [11:0] SIN_C = 12'd2320;

  // Quarter turn in angle units
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  // Configuration register indexes
  localparam logic [1:0] REG_OFFSET_FORWARD = 2'd0;
  localparam logic [1:0] REG_OFFSET_RIGHT   = 2'd1;
  localparam logic [1:0] REG_OFFSET_UP      = 2'd2;

  // Clamp a wide sum into the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [37:0] hi;
    logic signed [37:0] lo;
    hi = 38'sd2147483647;
    lo = -38'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== rtl/core/eop_sin.sv =====
// Four-stage pipelined Q1.15 sine of a 16-bit turn fraction.
module eop_sin (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [15:0] sin_val
);

  logic [1:0]  quad;
  logic [13:0] rem;
  logic [14:0] t;
  logic [15:0] z0;
  logic [31:0] zz;

  logic [15:0] z1, z2, z3;
  logic [15:0] zsq1, zsq2;
  logic        neg1, neg2, neg3;
  logic [14:0] inner;
  logic [15:0] poly;

  logic [27:0] m1;
  logic [30:0] m2;
  logic [31:0] m3;
  logic [16:0] s_raw;
  logic [15:0] s_lim;

  // Fold into a quarter turn and square
  always_comb begin
    quad = angle[15:14];
    rem  = angle[13:0];
    t    = quad[0] ? 15'(eop_pkg::QUARTER_TURN - {2'b00, rem}) : {1'b0, rem};
    z0   = {t, 1'b0};
    zz   = z0 * z0;
  end

  always_comb begin
    m1 = zsq1 * eop_pkg::SIN_C;
    m2 = zsq2 * inner;
    m3 = z3 * poly;
    s_raw = m3[31:15];
    s_lim = (s_raw > 17'd32767) ? 16'd32767 : s_raw[15:0];
  end

  // Advance the polynomial stages together
  always_ff @(posedge clk) begin
    if (en) begin
      z1      <= z0;
      zsq1    <= zz[30:15];
      neg1    <= quad[1];
      z2      <= z1;
      zsq2    <= zsq1;
      neg2    <= neg1;
      inner   <= 15'(eop_pkg::SIN_B - 15'(m1[27:15]));
      z3      <= z2;
      neg3    <= neg2;
      poly    <= 16'(eop_pkg::SIN_A - 16'(m2[30:15]));
      sin_val <= neg3 ? -$signed(s_lim) : $signed(s_lim);
    end
  end

endmodule

// ===== rtl/core/euler_offset_placement.sv =====
// Top level: eye position moved along Euler-angle basis vectors by set offsets.
//
//  channel  | signals                                        | dir
//  request  | in_valid/in_ready, entity_present, eye_*, angles | in
//  result   | out_valid/out_ready, place_x/y/z               | out
//  config   | APB psel/penable/pwrite/paddr/pwdata/prdata    | in/out
//
// The pipeline runs through 4 sine stages, then basis products, three-factor sums,
// offset scaling, and the saturating sum into the output register.
// One request is accepted every cycle unless out_ready stalls; throughput is one per clock.
// Reset clears stage valid bits and the offset registers to zero.
// A stall of out_ready freezes all stages together; nothing is lost.
module euler_offset_placement (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               entity_present,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic [15:0]        pitch,
  input  logic [15:0]        yaw,
  input  logic [15:0]        roll,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] place_x,
  output logic signed [31:0] place_y,
  output logic signed [31:0] place_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [31:0] offset_forward, offset_right, offset_up;
  logic        adv;
  logic [7:0]  vld;
  logic signed [31:0] ex_d [7];
  logic signed [31:0] ey_d [7];
  logic signed [31:0] ez_d [7];
  logic [6:0]  ent_d;

  logic signed [15:0] sx, cx, sy, cy, sz, cz;

  // stage 5 registers
  logic signed [31:0] szsx, czsx, fx5, fy5, fz5, rz5, uz5, czsy, czcy, szsy, szcy;
  logic signed [15:0] sy5, cy5;
  // stage 6 registers
  logic signed [32:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
  // stage 7 registers
  logic signed [35:0] tfx, tfy, tfz, trx, try_, trz, tux, tuy, tuz;

  logic signed [48:0] a_rx, a_ry, a_ux, a_uy;
  logic signed [48:0] p1, p2, p3, p4, q1, q2, q3, q4;
  logic signed [64:0] m_fx, m_fy, m_fz, m_rx, m_ry, m_rz, m_ux, m_uy, m_uz;
  logic signed [37:0] sum_x, sum_y, sum_z;

  localparam logic signed [48:0] HALF15 = 49'sd16384;
  localparam logic signed [64:0] HALF30 = 65'sd536870912;

  assign pready = 1'b1;

  // Write offsets on the APB access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_forward <= '0;
      offset_right   <= '0;
      offset_up      <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        eop_pkg::REG_OFFSET_FORWARD: offset_forward <= pwdata;
        eop_pkg::REG_OFFSET_RIGHT:   offset_right   <= pwdata;
        eop_pkg::REG_OFFSET_UP:      offset_up      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      eop_pkg::REG_OFFSET_FORWARD: prdata = offset_forward;
      eop_pkg::REG_OFFSET_RIGHT:   prdata = offset_right;
      eop_pkg::REG_OFFSET_UP:      prdata = offset_up;
      default:                     prdata = '0;
    endcase
  end

  // Advance the whole pipe unless the output holds an untaken request
  assign adv       = !vld[7] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  // Carry eye position and flag alongside the math
  always_ff @(posedge clk) begin
    if (adv) begin
      ex_d[0] <= eye_x;
      ey_d[0] <= eye_y;
      ez_d[0] <= eye_z;
      ent_d   <= {ent_d[5:0], entity_present};
      for (int i = 1; i < 7; i++) begin
        ex_d[i] <= ex_d[i-1];
        ey_d[i] <= ey_d[i-1];
        ez_d[i] <= ez_d[i-1];
      end
    end
  end

  eop_sin u_sx (.clk(clk), .en(adv), .angle(pitch), .sin_val(sx));
  eop_sin u_cx (.clk(clk), .en(adv), .angle(16'(pitch + eop_pkg::QUARTER_TURN)),
                .sin_val(cx));
  eop_sin u_sy (.clk(clk), .en(adv), .angle(yaw), .sin_val(sy));
  eop_sin u_cy (.clk(clk), .en(adv), .angle(16'(yaw + eop_pkg::QUARTER_TURN)),
                .sin_val(cy));
  eop_sin u_sz (.clk(clk), .en(adv), .angle(roll), .sin_val(sz));
  eop_sin u_cz (.clk(clk), .en(adv), .angle(16'(roll + eop_pkg::QUARTER_TURN)),
                .sin_val(cz));

  // Form two-factor basis products in Q30
  always_ff @(posedge clk) begin
    if (adv) begin
      szsx <= sz * sx;
      czsx <= cz * sx;
      fx5  <= cx * cy;
      fy5  <= cx * sy;
      fz5  <= -(32'(sx) <<< 15);
      rz5  <= -(sz * cx);
      uz5  <= cz * cx;
      czsy <= cz * sy;
      czcy <= cz * cy;
      szsy <= sz * sy;
      szcy <= sz * cy;
      sy5  <= sy;
      cy5  <= cy;
    end
  end

  // Three-factor sums in Q45, rounded to Q30
  always_comb begin
    p1 = szsx * cy5;
    p2 = szsx * sy5;
    p3 = czsx * cy5;
    p4 = czsx * sy5;
    q1 = czsy;
    q2 = czcy;
    q3 = szsy;
    q4 = szcy;
    a_rx = -p1 + (q1 <<< 15) + HALF15;
    a_ry = -p2 - (q2 <<< 15) + HALF15;
    a_ux =  p3 + (q3 <<< 15) + HALF15;
    a_uy =  p4 - (q4 <<< 15) + HALF15;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx <= 33'(a_rx >>> 15);
      ry <= 33'(a_ry >>> 15);
      ux <= 33'(a_ux >>> 15);
      uy <= 33'(a_uy >>> 15);
      fx <= 33'(fx5);
      fy <= 33'(fy5);
      fz <= 33'(fz5);
      rz <= 33'(rz5);
      uz <= 33'(uz5);
    end
  end

  // Scale each component by its offset and round to Q16
  always_comb begin
    m_fx = fx * offset_forward;
    m_fy = fy * offset_forward;
    m_fz = fz * offset_forward;
    m_rx = rx * offset_right;
    m_ry = ry * offset_right;
    m_rz = rz * offset_right;
    m_ux = ux * offset_up;
    m_uy = uy * offset_up;
    m_uz = uz * offset_up;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tfx  <= 36'((m_fx + HALF30) >>> 30);
      tfy  <= 36'((m_fy + HALF30) >>> 30);
      tfz  <= 36'((m_fz + HALF30) >>> 30);
      trx  <= 36'((m_rx + HALF30) >>> 30);
      try_ <= 36'((m_ry + HALF30) >>> 30);
      trz  <= 36'((m_rz + HALF30) >>> 30);
      tux  <= 36'((m_ux + HALF30) >>> 30);
      tuy  <= 36'((m_uy + HALF30) >>> 30);
      tuz  <= 36'((m_uz + HALF30) >>> 30);
    end
  end

  // Sum with the eye position and saturate; with no entity the eye position passes through
  always_comb begin
    sum_x = 38'(ex_d[6]) + 38'(tfx) + 38'(trx) + 38'(tux);
    sum_y = 38'(ey_d[6]) + 38'(tfy) + 38'(try_) + 38'(tuy);
    sum_z = 38'(ez_d[6]) + 38'(tfz) + 38'(trz) + 38'(tuz);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      place_x <= ent_d[6] ? eop_pkg::sat32(sum_x) : ex_d[6];
      place_y <= ent_d[6] ? eop_pkg::sat32(sum_y) : ey_d[6];
      place_z <= ent_d[6] ? eop_pkg::sat32(sum_z) : ez_d[6];
    end
  end

endmodule

// ===== sim/euler_offset_placement_tb.sv =====
// Testbench for euler_offset_placement: scoreboard prediction of placed positions.
module euler_offset_placement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VBITS = 30;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } place_t;

  // Fixed-point view math and the queue of placements still owed by the block
  class place_board;
    longint ofs_fwd, ofs_rgt, ofs_up;
    place_t owed[$];
    int errors;

    function longint rnd_shift(longint v, int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function longint sine(logic [15:0] ang);
      longint q, r, t, z, z2, inner, poly, s;
      q = ang[15:14];
      r = ang[13:0];
      t = q[0] ? 16384 - r : r;
      z = t * 2;
      z2 = (z * z) >> 15;
      inner = longint'(eop_pkg::SIN_B) - ((z2 * longint'(eop_pkg::SIN_C)) >> 15);
      poly = longint'(eop_pkg::SIN_A) - ((z2 * inner) >> 15);
      s = (z * poly) >> 15;
      if (s > 32767) s = 32767;
      return q[1] ? -s : s;
    endfunction

    function logic signed [31:0] move(longint eye, longint f, longint r, longint u);
      longint sum;
      sum = eye + rnd_shift(f * ofs_fwd, VBITS) + rnd_shift(r * ofs_rgt, VBITS)
            + rnd_shift(u * ofs_up, VBITS);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[31:0];
    endfunction

    function void note_request(logic ent, logic signed [31:0] ex, logic signed [31:0] ey,
                               logic signed [31:0] ez, logic [15:0] p, logic [15:0] yw,
                               logic [15:0] rl);
      longint sx, cx, sy, cy, sz, cz, szsx, czsx;
      place_t e;
      e.x = ex; e.y = ey; e.z = ez;
      if (ent) begin
        sx = sine(p);  cx = sine(16'(p + eop_pkg::QUARTER_TURN));
        sy = sine(yw); cy = sine(16'(yw + eop_pkg::QUARTER_TURN));
        sz = sine(rl); cz = sine(16'(rl + eop_pkg::QUARTER_TURN));
        szsx = sz * sx;
        czsx = cz * sx;
        e.x = move(ex, cx * cy, rnd_shift(-szsx * cy + cz * sy * 32768, 15),
                   rnd_shift(czsx * cy + sz * sy * 32768, 15));
        e.y = move(ey, cx * sy, rnd_shift(-szsx * sy - cz * cy * 32768, 15),
                   rnd_shift(czsx * sy - sz * cy * 32768, 15));
        e.z = move(ez, -sx * 32768, -sz * cx, cz * cx);
      end
      owed.push_back(e);
    endfunction

    function void check_place(logic signed [31:0] ax, logic signed [31:0] ay,
                              logic signed [31:0] az);
      place_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time, ax, ay, az);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (ax !== e.x) begin
        $display("%0t: place_x expected %h actual %h", $time, e.x, ax); errors++;
      end
      if (ay !== e.y) begin
        $display("%0t: place_y expected %h actual %h", $time, e.y, ay); errors++;
      end
      if (az !== e.z) begin
        $display("%0t: place_z expected %h actual %h", $time, e.z, az); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, entity_present, out_valid, out_ready;
  logic signed [31:0] eye_x, eye_y, eye_z, place_x, place_y, place_z;
  logic [15:0] pitch, yaw, roll;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  int send_idle, recv_idle;
  place_board board;

  euler_offset_placement u_dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("euler_offset_placement_tb: FAIL");
    $finish;
  end

  // Receiver: stall at random, check each accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_place(place_x, place_y, place_z);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      eop_pkg::REG_OFFSET_FORWARD: board.ofs_fwd = longint'($signed(val));
      eop_pkg::REG_OFFSET_RIGHT:   board.ofs_rgt = longint'($signed(val));
      eop_pkg::REG_OFFSET_UP:      board.ofs_up  = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_request(logic ent, logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                              logic [15:0] p, logic [15:0] yw, logic [15:0] rl);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; entity_present <= ent;
    eye_x <= ex; eye_y <= ey; eye_z <= ez; pitch <= p; yaw <= yw; roll <= rl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(ent, ex, ey, ez, p, yw, rl);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(3))
      0: return 16'($urandom_range(7)) * 16'h2000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      send_request(($urandom_range(9) != 0), pick32(), pick32(), pick32(),
                   pick_angle(), pick_angle(), pick_angle());
    end
  endtask

  initial begin
    logic [31:0] ofs [3];
    board = new();
    rst = 1; in_valid = 0; out_ready = 0; entity_present = 0;
    eye_x = 0; eye_y = 0; eye_z = 0; pitch = 0; yaw = 0; roll = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    send_idle = 0; recv_idle = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: small whole offsets, eighth-turn angles, passthrough, saturation
    write_reg(eop_pkg::REG_OFFSET_FORWARD, 32'h0001_0000);
    write_reg(eop_pkg::REG_OFFSET_RIGHT, 32'h0002_0000);
    write_reg(eop_pkg::REG_OFFSET_UP, 32'hFFFD_0000);
    for (int k = 0; k < 8; k++) begin
      send_request(1, 32'h0010_0000, 32'hFFF0_0000, 0, 16'(k) * 16'h2000,
                   16'(7 - k) * 16'h2000, 16'(k) * 16'h4000);
    end
    send_request(0, 32'h7FFFFFFF, 32'h80000000, 32'h1234_5678, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(1, 0, 0, 0, 16'hFFFF, 16'h0001, 16'h8000);
    drain();
    write_reg(eop_pkg::REG_OFFSET_FORWARD, 32'h7FFFFFFF);
    write_reg(eop_pkg::REG_OFFSET_RIGHT, 32'h80000000);
    write_reg(eop_pkg::REG_OFFSET_UP, 32'h7FFFFFFF);
    send_request(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_request(1, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000);
    send_request(1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h4000, 16'hC000, 16'h4000);
    send_request(1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hC000, 16'h4000, 16'hC000);
    // Hold off the sender until everything is back
    drain();

    // Random phases under three idling patterns, fresh offsets for each
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 15 : (ph == 1) ? 46 : 0;
      recv_idle = (ph == 0) ? 46 : (ph == 1) ? 15 : 0;
      for (int j = 0; j < 3; j++) ofs[j] = pick32();
      if (ph == 2) ofs[0] = 32'h80000000;
      write_reg(eop_pkg::REG_OFFSET_FORWARD, ofs[0]);
      write_reg(eop_pkg::REG_OFFSET_RIGHT, ofs[1]);
      write_reg(eop_pkg::REG_OFFSET_UP, ofs[2]);
      random_phase(160);
      drain();
    end

    if (board.errors == 0) begin
      $display("euler_offset_placement_tb: PASS");
    end else begin
      $display("euler_offset_placement_tb: FAIL");
    end
    $finish;
  end
endmodule
